// File: hw/rtl/gigr_pkg.sv
// Shared types and constants of the grid split remapper.
// No dependencies; every other file uses these names by scope.
`timescale 1ns / 1ps
`default_nettype none
package gigr_pkg;

  localparam int POS_W  = 12;          // source coordinate
  localparam int CNT_W  = 13;          // size and block count registers
  localparam int BAND_W = 8;           // band thickness register
  localparam int COL_W  = 8;           // one colour component
  localparam int DST_W  = 20;          // destination coordinate
  localparam int NUM_W  = 2 * CNT_W;   // (2*pos+1)*cnt
  localparam int DIV_W  = CNT_W + 1;   // 2*size
  localparam int LIM_W  = CNT_W + DIV_W;
  localparam int PROD_W = CNT_W + BAND_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam int DIV_BITS   = CNT_W;   // quotient is below cnt once the clamp is split off
  localparam int STG_DIV0   = 2;
  localparam int STG_MUL    = STG_DIV0 + DIV_BITS;
  localparam int STG_OUT    = STG_MUL + 1;
  localparam int NUM_STAGES = STG_OUT + 1;

  localparam logic [DST_W-1:0] DST_MAX = {DST_W{1'b1}};

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_CNT_X          = 3'd2;
  localparam logic [2:0] REG_CNT_Y          = 3'd3;
  localparam logic [2:0] REG_BAND_THICKNESS = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0]  image_width;
    logic [CNT_W-1:0]  image_height;
    logic [CNT_W-1:0]  cnt_x;
    logic [CNT_W-1:0]  cnt_y;
    logic [BAND_W-1:0] band_thickness;
  } gigr_cfg_t;

endpackage
`default_nettype wire

// File: hw/rtl/gigr_apb_regs.sv
// APB-style configuration registers of the grid split remapper.
// Depends on gigr_pkg for register codes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none
module gigr_apb_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gigr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [gigr_pkg::DATA_W-1:0]   pwdata,
  output logic      [gigr_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output gigr_pkg::gigr_cfg_t                cfg
);

  gigr_pkg::gigr_cfg_t cfg_r;
  logic [2:0]          idx;
  logic                wr_en;

  assign idx    = paddr[gigr_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= gigr_pkg::CNT_W'(1);
      cfg_r.image_height   <= gigr_pkg::CNT_W'(1);
      cfg_r.cnt_x          <= gigr_pkg::CNT_W'(1);
      cfg_r.cnt_y          <= gigr_pkg::CNT_W'(1);
      cfg_r.band_thickness <= gigr_pkg::BAND_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        gigr_pkg::REG_IMAGE_WIDTH:    cfg_r.image_width    <= pwdata[gigr_pkg::CNT_W-1:0];
        gigr_pkg::REG_IMAGE_HEIGHT:   cfg_r.image_height   <= pwdata[gigr_pkg::CNT_W-1:0];
        gigr_pkg::REG_CNT_X:          cfg_r.cnt_x          <= pwdata[gigr_pkg::CNT_W-1:0];
        gigr_pkg::REG_CNT_Y:          cfg_r.cnt_y          <= pwdata[gigr_pkg::CNT_W-1:0];
        gigr_pkg::REG_BAND_THICKNESS: cfg_r.band_thickness <= pwdata[gigr_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gigr_pkg::REG_IMAGE_WIDTH:    prdata = gigr_pkg::DATA_W'(cfg_r.image_width);
      gigr_pkg::REG_IMAGE_HEIGHT:   prdata = gigr_pkg::DATA_W'(cfg_r.image_height);
      gigr_pkg::REG_CNT_X:          prdata = gigr_pkg::DATA_W'(cfg_r.cnt_x);
      gigr_pkg::REG_CNT_Y:          prdata = gigr_pkg::DATA_W'(cfg_r.cnt_y);
      gigr_pkg::REG_BAND_THICKNESS: prdata = gigr_pkg::DATA_W'(cfg_r.band_thickness);
      default:                      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/gigr_axis.sv
// One axis of the remapper: multiply, clamp test, pipelined restoring divider,
// band offset multiply and saturating add. Depends on gigr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gigr_axis (
  input  wire logic                                clk,
  input  wire logic [gigr_pkg::NUM_STAGES-1:0]     en,
  input  wire logic [gigr_pkg::POS_W-1:0]          pos_i,
  input  wire logic [gigr_pkg::CNT_W-1:0]          size_i,
  input  wire logic [gigr_pkg::CNT_W-1:0]          cnt_i,
  input  wire logic [gigr_pkg::BAND_W-1:0]         band_i,
  output logic      [gigr_pkg::DST_W-1:0]          dst_o
);

  localparam int NB = gigr_pkg::DIV_BITS;

  logic [gigr_pkg::POS_W-1:0]  pos_r [0:gigr_pkg::STG_MUL];
  logic [gigr_pkg::NUM_W-1:0]  num_r;
  logic [gigr_pkg::LIM_W-1:0]  lim_r;
  logic [gigr_pkg::NUM_W-1:0]  rem_r [0:NB-1];
  logic [NB-1:0]               q_r   [0:NB];
  logic                        ovf_r [0:NB];
  logic [gigr_pkg::PROD_W-1:0] prod_r;
  logic [gigr_pkg::DST_W-1:0]  dst_r;

  logic [gigr_pkg::CNT_W-1:0]  odd;
  logic [gigr_pkg::DIV_W-1:0]  dd;
  logic [gigr_pkg::NUM_W-1:0]  num_nxt;
  logic [gigr_pkg::LIM_W-1:0]  lim_nxt;
  logic                        zero_cfg;
  logic [gigr_pkg::CNT_W-1:0]  blk;
  logic [gigr_pkg::PROD_W-1:0] prod_nxt;
  logic [gigr_pkg::SUM_W-1:0]  sum;
  logic [gigr_pkg::DST_W-1:0]  dst_nxt;

  // Midpoint rule in integers: (x+0.5)*cnt/size == (2x+1)*cnt / (2*size).
  assign odd     = {pos_i, 1'b1};
  assign dd      = {size_i, 1'b0};
  assign num_nxt = gigr_pkg::NUM_W'(odd) * gigr_pkg::NUM_W'(cnt_i);
  assign lim_nxt = gigr_pkg::LIM_W'(cnt_i) * gigr_pkg::LIM_W'(dd);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos_r[0] <= pos_i;
      num_r    <= num_nxt;
      lim_r    <= lim_nxt;
    end
  end

  // Quotient at or above cnt is clamped, so the divider needs only NB bits.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pos_r[1] <= pos_r[0];
      ovf_r[0] <= gigr_pkg::LIM_W'(num_r) >= lim_r;
      rem_r[0] <= num_r;
      q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_div
    localparam int SH = NB - 1 - j;
    logic [gigr_pkg::NUM_W-1:0] sub;
    logic                       take;

    assign sub  = gigr_pkg::NUM_W'(dd) << SH;
    assign take = rem_r[j] >= sub;

    always_ff @(posedge clk) begin
      if (en[gigr_pkg::STG_DIV0+j]) begin
        pos_r[gigr_pkg::STG_DIV0+j] <= pos_r[gigr_pkg::STG_DIV0+j-1];
        ovf_r[j+1]                  <= ovf_r[j];
        q_r[j+1]                    <= {q_r[j][NB-2:0], take};
      end
    end

    if (j < NB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[gigr_pkg::STG_DIV0+j]) begin
          rem_r[j+1] <= take ? rem_r[j] - sub : rem_r[j];
        end
      end
    end
  end

  assign zero_cfg = (size_i == '0) || (cnt_i == '0);

  always_comb begin
    if (zero_cfg) begin
      blk = '0;
    end else if (ovf_r[NB]) begin
      blk = cnt_i - gigr_pkg::CNT_W'(1);
    end else begin
      blk = q_r[NB];
    end
  end

  assign prod_nxt = gigr_pkg::PROD_W'(blk) * gigr_pkg::PROD_W'(band_i);

  always_ff @(posedge clk) begin
    if (en[gigr_pkg::STG_MUL]) begin
      pos_r[gigr_pkg::STG_MUL] <= pos_r[gigr_pkg::STG_MUL-1];
      prod_r                   <= prod_nxt;
    end
  end

  // Saturate at the top of the destination range.
  assign sum     = gigr_pkg::SUM_W'(pos_r[gigr_pkg::STG_MUL]) + gigr_pkg::SUM_W'(prod_r);
  assign dst_nxt = (sum > gigr_pkg::SUM_W'(gigr_pkg::DST_MAX)) ? gigr_pkg::DST_MAX
                                                              : sum[gigr_pkg::DST_W-1:0];

  always_ff @(posedge clk) begin
    if (en[gigr_pkg::STG_OUT]) begin
      dst_r <= dst_nxt;
    end
  end

  assign dst_o = dst_r;

endmodule
`default_nettype wire

// File: hw/rtl/image_grid_split_remap_top.sv
// Top level of the grid split remapper: pixel pipeline control, colour line,
// two axis datapaths and the configuration port. Depends on gigr_pkg,
// gigr_apb_regs and gigr_axis.
`timescale 1ns / 1ps
`default_nettype none
// One source pixel (column, row, colour) goes in per beat and its place in the
// split image comes out of the last stage; the block takes one pixel every
// clock while in_ready is high. Both axes run in parallel through the same
// 17 register stages: a product stage, a clamp test, a restoring divider
// that settles one quotient bit per stage over 13 stages, the band offset
// multiply and a saturating add. Each stage holds its own valid bit, so a stall
// on the output fills empty stages first and in_ready stays high while any
// stage is free. Write the registers only while no pixel is in flight.
module image_grid_split_remap_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [gigr_pkg::POS_W-1:0]    in_src_x,
  input  wire logic [gigr_pkg::POS_W-1:0]    in_src_y,
  input  wire logic [gigr_pkg::COL_W-1:0]    in_red_in,
  input  wire logic [gigr_pkg::COL_W-1:0]    in_green_in,
  input  wire logic [gigr_pkg::COL_W-1:0]    in_blue_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [gigr_pkg::DST_W-1:0]    out_dst_x,
  output logic      [gigr_pkg::DST_W-1:0]    out_dst_y,
  output logic      [gigr_pkg::COL_W-1:0]    out_red_out,
  output logic      [gigr_pkg::COL_W-1:0]    out_green_out,
  output logic      [gigr_pkg::COL_W-1:0]    out_blue_out,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gigr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [gigr_pkg::DATA_W-1:0]   pwdata,
  output logic      [gigr_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int NS  = gigr_pkg::NUM_STAGES;
  localparam int PXW = 3 * gigr_pkg::COL_W;

  gigr_pkg::gigr_cfg_t cfg;
  logic [NS-1:0]       vld_r;
  logic [NS-1:0]       rdy;
  logic [NS-1:0]       up_vld;
  logic [PXW-1:0]      col_r [0:NS-1];

  gigr_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A stage takes a beat when it is empty or its own beat moves on.
  assign rdy[NS-1]    = !vld_r[NS-1] || out_ready;
  assign up_vld[0]    = in_valid;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k]      = !vld_r[k] || rdy[k+1];
    assign up_vld[k+1] = vld_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= up_vld[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      col_r[0] <= {in_red_in, in_green_in, in_blue_in};
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        col_r[k] <= col_r[k-1];
      end
    end
  end

  gigr_axis u_axis_x (
    .clk    (clk),
    .en     (rdy),
    .pos_i  (in_src_x),
    .size_i (cfg.image_width),
    .cnt_i  (cfg.cnt_x),
    .band_i (cfg.band_thickness),
    .dst_o  (out_dst_x)
  );

  gigr_axis u_axis_y (
    .clk    (clk),
    .en     (rdy),
    .pos_i  (in_src_y),
    .size_i (cfg.image_height),
    .cnt_i  (cfg.cnt_y),
    .band_i (cfg.band_thickness),
    .dst_o  (out_dst_y)
  );

  assign in_ready      = rdy[0];
  assign out_valid     = vld_r[NS-1];
  assign out_red_out   = col_r[NS-1][PXW-1 -: gigr_pkg::COL_W];
  assign out_green_out = col_r[NS-1][gigr_pkg::COL_W +: gigr_pkg::COL_W];
  assign out_blue_out  = col_r[NS-1][gigr_pkg::COL_W-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/gigr_checker.sv
// Port-level checks of the grid split remapper and their bind to the top level.
// Depends on gigr_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none
module gigr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [gigr_pkg::DST_W-1:0]    out_dst_x,
  input wire logic [gigr_pkg::DST_W-1:0]    out_dst_y,
  input wire logic [gigr_pkg::COL_W-1:0]    out_red_out,
  input wire logic [gigr_pkg::COL_W-1:0]    out_green_out,
  input wire logic [gigr_pkg::COL_W-1:0]    out_blue_out
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dst_x) && $stable(out_dst_y)
      && $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out))
    else $error("result beat changed while stalled");

  // Reset drains the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // A consumer that takes beats never blocks the producer.
  a_flow_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // An empty output stage means every stage can move.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

endmodule

bind image_grid_split_remap_top gigr_checker u_gigr_checker (.*);
`default_nettype wire
